### rtl/lit_pkg.sv
`timescale 1ns / 1ps

package lit_pkg;

	localparam int COUNT_BITS_DEF = 32;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	localparam logic [5:0] REG_ID   = 6'h02;
	localparam logic [5:0] REG_EOI  = 6'h0B;
	localparam logic [5:0] REG_SPUR = 6'h0F;
	localparam logic [5:0] REG_LVT  = 6'h32;
	localparam logic [5:0] REG_INIT = 6'h38;
	localparam logic [5:0] REG_CUR  = 6'h39;
	localparam logic [5:0] REG_DIV  = 6'h3E;

	localparam logic [3:0] DIV_KEEP_MASK = 4'b1011;
	localparam int         LVT_MASK_POS  = 16;
	localparam int         LVT_PER_POS   = 17;
	localparam logic [9:0] SPUR_RESET    = 10'h0FF;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_fire;
		logic [7:0]  irq_vector;
	} result_t;

	// prescaler period 2^(v+1), v from code bits 3,1,0; v = 7 wraps to 1
	function automatic logic [7:0] divisor(input logic [3:0] code);
		logic [2:0] v;
		begin
			v = {code[3], code[1:0]};
			divisor = 8'd1 << (v + 3'd1);
		end
	endfunction

endpackage

### rtl/lit_timer.sv
`timescale 1ns / 1ps

module lit_timer #(
	parameter int COUNT_BITS = lit_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         cmd,
	input  logic [5:0]         reg_index,
	input  logic [31:0]        write_data,
	input  logic [7:0]         apic_id,
	output lit_pkg::result_t   result
);

	logic [7:0]            vector_q;
	logic                  masked_q;
	logic                  periodic_q;
	logic [3:0]            div_q;
	logic [COUNT_BITS-1:0] init_q;
	logic [COUNT_BITS-1:0] cur_q;
	logic [6:0]            pre_q;
	logic [9:0]            spur_q;

	logic [COUNT_BITS-1:0] cur_d;
	logic [COUNT_BITS-1:0] dec;
	logic [6:0]            pre_d;
	logic                  is_write;

	assign dec = cur_q - COUNT_BITS'(1);
	assign is_write = accept && (lit_pkg::cmd_t'(cmd) == lit_pkg::CMD_WRITE);

	always_comb begin
		cur_d = cur_q;
		pre_d = pre_q;
		result = '0;
		case (lit_pkg::cmd_t'(cmd))
			lit_pkg::CMD_TICK: begin
				if (cur_q != '0) begin
					if (({1'b0, pre_q} + 8'd1) >= lit_pkg::divisor(div_q)) begin
						pre_d = '0;
						cur_d = dec;
						if (dec == '0) begin
							if (!masked_q) begin
								result.irq_fire = 1'b1;
								result.irq_vector = vector_q;
							end
							if (periodic_q) begin
								cur_d = init_q;
							end
						end
					end else begin
						pre_d = pre_q + 7'd1;
					end
				end
			end
			lit_pkg::CMD_READ: begin
				case (reg_index)
					lit_pkg::REG_ID:   result.read_data = {apic_id, 24'd0};
					lit_pkg::REG_SPUR: result.read_data = 32'(spur_q);
					lit_pkg::REG_LVT: begin
						result.read_data = 32'(vector_q);
						result.read_data[lit_pkg::LVT_MASK_POS] = masked_q;
						result.read_data[lit_pkg::LVT_PER_POS] = periodic_q;
					end
					lit_pkg::REG_INIT: result.read_data = 32'(init_q);
					lit_pkg::REG_CUR:  result.read_data = 32'(cur_q);
					lit_pkg::REG_DIV:  result.read_data = 32'(div_q);
					default:           result.read_data = '0;
				endcase
			end
			lit_pkg::CMD_WRITE: begin
				if (reg_index == lit_pkg::REG_INIT) begin
					cur_d = write_data[COUNT_BITS-1:0];
					pre_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_q   <= '0;
			masked_q   <= 1'b1;
			periodic_q <= 1'b0;
			div_q      <= '0;
			init_q     <= '0;
			cur_q      <= '0;
			pre_q      <= '0;
			spur_q     <= lit_pkg::SPUR_RESET;
		end else begin
			if (accept) begin
				cur_q <= cur_d;
				pre_q <= pre_d;
			end
			if (is_write) begin
				case (reg_index)
					lit_pkg::REG_SPUR: spur_q <= write_data[9:0];
					lit_pkg::REG_LVT: begin
						vector_q   <= write_data[7:0];
						masked_q   <= write_data[lit_pkg::LVT_MASK_POS];
						periodic_q <= write_data[lit_pkg::LVT_PER_POS];
					end
					lit_pkg::REG_INIT: init_q <= write_data[COUNT_BITS-1:0];
					lit_pkg::REG_DIV:  div_q <= write_data[3:0] & lit_pkg::DIV_KEEP_MASK;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

### rtl/lit_out_reg.sv
`timescale 1ns / 1ps

module lit_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lit_pkg::result_t  in_result,
	output logic              out_valid,
	input  logic              out_ready,
	output lit_pkg::result_t  out_result
);

	logic             valid_q;
	lit_pkg::result_t result_q;

	assign in_ready   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_q <= in_result;
		end
	end

endmodule

### rtl/local_interrupt_timer_registers_core.sv
`timescale 1ns / 1ps

// channel   direction  signals                      contents
// s_*       in         s_tvalid/s_tready/tdata/tuser  tick, register read or write
// m_*       out        m_tvalid/m_tready/tdata/tuser  read data, timer interrupt
// apb       in         psel/penable/pwrite/paddr...   apic_id at address 0
//
// One transfer in, one transfer out; one item per cycle while m_tready is high or the
// output register is empty; results are registered in the output register.
// Timer state updates at the edge an item is accepted; s_tready drops only while
// the output register is full and m_tready is low.
// arst_n clears timer state and the output valid; mask resets set, spurious to 0xFF.

module local_interrupt_timer_registers_core #(
	parameter int COUNT_BITS = lit_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // reg_index[5:0], write_data[37:6], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_data[31:0], irq_vector[39:32]
	output logic [0:0]  m_tuser,   // irq_fire[0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]       apic_id_q;
	logic             accept;
	lit_pkg::result_t core_result;
	lit_pkg::result_t out_result;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, apic_id_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apic_id_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			apic_id_q <= pwdata[7:0];
		end
	end

	assign accept = s_tvalid && s_tready;

	lit_timer #(
		.COUNT_BITS(COUNT_BITS)
	) u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (s_tuser),
		.reg_index (s_tdata[5:0]),
		.write_data(s_tdata[37:6]),
		.apic_id   (apic_id_q),
		.result    (core_result)
	);

	lit_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_result (core_result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_result(out_result)
	);

	assign m_tdata = {out_result.irq_vector, out_result.read_data};
	assign m_tuser = out_result.irq_fire;

endmodule

### tb/local_interrupt_timer_registers_core_test.sv
`timescale 1ns / 1ps

module local_interrupt_timer_registers_core_test;
	import lit_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam logic [2:0] APIC_ID_ADDR = 3'd0;
	localparam int QUIET_LIMIT = 400;
	localparam int NUM_ROWS = 26;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  idx;
		logic [31:0] data;
		logic        known;
		result_t     want;
	} timer_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // reg_index[5:0], write_data[37:6], zero pad
	logic [1:0]  s_tuser;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // read_data[31:0], irq_vector[39:32]
	logic [0:0]  m_tuser;   // irq_fire[0]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// typed expectation riding along with the current stimulus transfer
	logic    row_known;
	result_t row_want;

	// timer predictor state
	logic [7:0]  cfg_apic_id;
	logic [7:0]  t_vec;
	logic        t_masked;
	logic        t_periodic;
	logic [3:0]  t_div;
	logic [31:0] t_init;
	logic [31:0] t_cur;
	logic [6:0]  t_pre;
	logic [9:0]  t_spur;

	result_t expected_q[$];
	int      mismatch_count = 0;
	int      items_sent = 0;
	int      quiet_cycles = 0;
	bit      idle_on = 1'b1;

	timer_row_t timer_rows [0:NUM_ROWS-1] = '{
		'{CMD_READ,  REG_ID,   32'h0,         1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_READ,  REG_SPUR, 32'h0,         1'b1, '{32'h0000_00FF, 1'b0, 8'h00}},
		'{CMD_READ,  REG_LVT,  32'hFFFF_FFFF, 1'b1, '{32'h0001_0000, 1'b0, 8'h00}},
		'{CMD_READ,  REG_DIV,  32'h0,         1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_READ,  6'h3F,    32'h0,         1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_TICK,  REG_INIT, 32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_NOP,   REG_LVT,  32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_WRITE, REG_SPUR, 32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_READ,  REG_SPUR, 32'h0,         1'b1, '{32'h0000_03FF, 1'b0, 8'h00}},
		'{CMD_WRITE, REG_DIV,  32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_READ,  REG_DIV,  32'h0,         1'b1, '{32'h0000_000B, 1'b0, 8'h00}},
		'{CMD_WRITE, REG_ID,   32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_WRITE, REG_CUR,  32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_WRITE, REG_EOI,  32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_READ,  REG_EOI,  32'h0,         1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_WRITE, REG_LVT,  32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_READ,  REG_LVT,  32'h0,         1'b1, '{32'h0003_00FF, 1'b0, 8'h00}},
		'{CMD_WRITE, REG_LVT,  32'h0002_00FF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_WRITE, REG_INIT, 32'h0000_0001, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_TICK,  6'h00,    32'h0,         1'b1, '{32'h0,       1'b1, 8'hFF}},
		'{CMD_TICK,  6'h3F,    32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b1, 8'hFF}},
		'{CMD_WRITE, REG_LVT,  32'h0003_0042, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_TICK,  6'h00,    32'h0,         1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_WRITE, REG_INIT, 32'hFFFF_FFFF, 1'b1, '{32'h0,       1'b0, 8'h00}},
		'{CMD_TICK,  6'h00,    32'h0,         1'b0, '{32'h0,       1'b0, 8'h00}},
		'{CMD_READ,  REG_CUR,  32'h0,         1'b0, '{32'h0,       1'b0, 8'h00}}
	};

	local_interrupt_timer_registers_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic result_t timer_step(logic [1:0] cmd, logic [5:0] idx, logic [31:0] data);
		result_t r;
		logic [2:0] sel;
		int period;
		r = '0;
		case (cmd)
			CMD_TICK: begin
				if (t_cur != 32'h0) begin
					sel = {t_div[3], t_div[1:0]};
					period = (sel == 3'd7) ? 1 : (2 << sel);
					if (t_pre + 1 >= period) begin
						t_pre = '0;
						t_cur = t_cur - 32'd1;
						if (t_cur == 32'h0) begin
							if (!t_masked) begin
								r.irq_fire = 1'b1;
								r.irq_vector = t_vec;
							end
							if (t_periodic)
								t_cur = t_init;
						end
					end else begin
						t_pre = t_pre + 7'd1;
					end
				end
			end
			CMD_READ: begin
				case (idx)
					REG_ID:   r.read_data = {cfg_apic_id, 24'h0};
					REG_SPUR: r.read_data = {22'h0, t_spur};
					REG_LVT:  r.read_data = {14'h0, t_periodic, t_masked, 8'h0, t_vec};
					REG_INIT: r.read_data = t_init;
					REG_CUR:  r.read_data = t_cur;
					REG_DIV:  r.read_data = {28'h0, t_div};
					default:  r.read_data = 32'h0;
				endcase
			end
			CMD_WRITE: begin
				case (idx)
					REG_SPUR: t_spur = data[9:0];
					REG_LVT: begin
						t_vec = data[7:0];
						t_masked = data[LVT_MASK_POS];
						t_periodic = data[LVT_PER_POS];
					end
					REG_INIT: begin
						t_init = data;
						t_cur = data;
						t_pre = '0;
					end
					REG_DIV: t_div = data[3:0] & DIV_KEEP_MASK;
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	// result check first, then queue the prediction for the transfer taken at this edge
	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.read_data = m_tdata[31:0];
				got.irq_vector = m_tdata[39:32];
				got.irq_fire = m_tuser[0];
				if (expected_q.size() == 0) begin
					log_mismatch($sformatf("unexpected result rd=%h fire=%b vec=%h",
						got.read_data, got.irq_fire, got.irq_vector));
				end else begin
					want = expected_q.pop_front();
					if (got.read_data !== want.read_data || got.irq_fire !== want.irq_fire ||
							got.irq_vector !== want.irq_vector)
						log_mismatch($sformatf(
							"exp rd=%h fire=%b vec=%h, got rd=%h fire=%b vec=%h",
							want.read_data, want.irq_fire, want.irq_vector,
							got.read_data, got.irq_fire, got.irq_vector));
				end
			end
			if (s_tvalid && s_tready) begin
				want = timer_step(s_tuser, s_tdata[5:0], s_tdata[37:6]);
				if (row_known)
					want = row_want;
				expected_q.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [5:0] idx,
			input logic [31:0] data, input logic known = 1'b0, input result_t want = '0);
		int gap;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, data, idx};
		s_tuser <= cmd;
		row_known <= known;
		row_want <= want;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic drain_all();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [7:0] id);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APIC_ID_ADDR;
		pwdata <= {24'($urandom_range(0, 16777215)), id};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_apic_id = id;
	endtask

	task automatic apb_check_read();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= APIC_ID_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== {24'h0, cfg_apic_id})
			log_mismatch($sformatf("apic_id read exp %h got %h", {24'h0, cfg_apic_id}, prdata));
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// divide code weighted toward short prescaler periods so the timer expires often
	function automatic logic [31:0] rand_div_word();
		logic [2:0] sel;
		logic [31:0] d;
		case ($urandom_range(0, 5))
			0, 1: sel = 3'd7;
			2: sel = 3'd0;
			3: sel = 3'd1;
			4: sel = 3'd2;
			default: sel = 3'($urandom_range(0, 7));
		endcase
		d = $urandom;
		d[3] = sel[2];
		d[1:0] = sel[1:0];
		return d;
	endfunction

	function automatic logic [5:0] any_reg();
		case ($urandom_range(0, 8))
			0: return REG_ID;
			1: return REG_EOI;
			2: return REG_SPUR;
			3: return REG_LVT;
			4: return REG_INIT;
			5: return REG_CUR;
			6: return REG_DIV;
			default: return 6'($urandom_range(0, 63));
		endcase
	endfunction

	task automatic run_random(input int n);
		int stop_at;
		int k;
		int r;
		logic [5:0] idx;
		logic [31:0] d;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				// program the timer, then let it run with occasional interference
				d = $urandom;
				d[LVT_MASK_POS] = ($urandom_range(0, 3) == 0);
				send_item(CMD_WRITE, REG_LVT, d);
				send_item(CMD_WRITE, REG_DIV, rand_div_word());
				k = $urandom_range(0, 15);
				d = (k == 0) ? 32'h0 : (k == 1) ? $urandom : $urandom_range(1, 6);
				send_item(CMD_WRITE, REG_INIT, d);
				k = $urandom_range(8, 40);
				repeat (k) begin
					r = $urandom_range(0, 19);
					if (r < 2)
						send_item(CMD_READ, any_reg(), $urandom);
					else if (r == 2)
						send_item(CMD_WRITE, REG_DIV, rand_div_word());
					else if (r == 3)
						send_item(CMD_WRITE, REG_LVT, $urandom);
					else
						send_item(CMD_TICK, 6'($urandom_range(0, 63)), $urandom);
				end
			end else if (r < 8) begin
				repeat ($urandom_range(1, 5))
					send_item(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), $urandom);
			end else begin
				idx = any_reg();
				send_item(CMD_WRITE, idx, $urandom);
				send_item(CMD_READ, idx, $urandom);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		row_known <= 1'b0;
		row_want <= '0;
		cfg_apic_id = 8'h00;
		t_vec = 8'h00;
		t_masked = 1'b1;
		t_periodic = 1'b0;
		t_div = 4'h0;
		t_init = 32'h0;
		t_cur = 32'h0;
		t_pre = '0;
		t_spur = SPUR_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_check_read();
		for (int i = 0; i < NUM_ROWS; i++)
			send_item(timer_rows[i].cmd, timer_rows[i].idx, timer_rows[i].data,
				timer_rows[i].known, timer_rows[i].want);

		drain_all();
		apb_write(8'hFF);
		apb_check_read();
		run_random(65);
		drain_all();
		run_random(65);

		drain_all();
		idle_on = 1'b0;
		apb_write(8'($urandom_range(1, 254)));
		apb_check_read();
		run_random(130);

		drain_all();
		idle_on = 1'b1;
		apb_write(8'h00);
		apb_check_read();
		run_random(130);

		drain_all();
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
rtl/lit_pkg.sv
rtl/lit_timer.sv
rtl/lit_out_reg.sv
rtl/local_interrupt_timer_registers_core.sv
tb/local_interrupt_timer_registers_core_test.sv
